// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define E2Q_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define E2Q_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== hdl/e2q_pkg.sv =====
package e2q_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int ANGLE_W = 17;
  localparam int IN_TDATA_W = ((3 * ANGLE_W + 7) / 8) * 8;

  // angle handling, half angle in 1/256 degree units
  localparam int HALF_TURN_UNITS = 92160;
  localparam int QUARTER_UNITS = 23040;
  localparam int EIGHTH_UNITS = 11520;
  localparam int RAD_PER_UNIT_Q40 = 74961321;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // sincos unit latency and square root stage count (two root bits per stage)
  localparam int LAT_SC = 17;
  localparam int SQ_STAGES = 16;

  // taylor divisors and their reciprocals scaled by 2^31
  localparam logic [6:0] SIN_DIV [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_DIV [4] = '{7'd90, 7'd56, 7'd30, 7'd12};
  localparam logic [28:0] SIN_RCP [4] = '{
    29'(64'd2147483648 / 64'd72), 29'(64'd2147483648 / 64'd42),
    29'(64'd2147483648 / 64'd20), 29'(64'd2147483648 / 64'd6)};
  localparam logic [28:0] COS_RCP [4] = '{
    29'(64'd2147483648 / 64'd90), 29'(64'd2147483648 / 64'd56),
    29'(64'd2147483648 / 64'd30), 29'(64'd2147483648 / 64'd12)};

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sincos_t;

  // unsigned q30 product, rounded half up
  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'(1) << 29);
    return p[60:30];
  endfunction

  // signed q30 product, rounded half away from zero
  function automatic logic signed [31:0] mul_s30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [30:0] ma;
    logic [30:0] mb;
    logic [30:0] m;
    ma = a[31] ? 31'(-a) : a[30:0];
    mb = b[31] ? 31'(-b) : b[30:0];
    m = mul_q30(ma, mb);
    return (a[31] ^ b[31]) ? -signed'({1'b0, m}) : signed'({1'b0, m});
  endfunction

  // floor(a / d) from the reciprocal product, one correction step
  function automatic logic [28:0] div_fix(input logic [30:0] a, input logic [59:0] prod,
                                          input logic [6:0] d);
    logic [28:0] q0;
    logic [31:0] r;
    q0 = prod[59:31];
    r = {1'b0, a} - 32'(q0) * 32'(d);
    return (r >= 32'(d)) ? q0 + 29'd1 : q0;
  endfunction

endpackage

// ===== hdl/e2q_sincos.sv =====
module e2q_sincos (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] angle_i,
  output e2q_pkg::sincos_t                  sc_o
);
  import e2q_pkg::*;

  localparam int NPH = 4;
  localparam int NLN = 3 * NPH + 1;
  localparam int NFL = NLN + 3;

  // fold stage
  logic signed [17:0] ang_ext;
  logic signed [17:0] ang_wrap;
  logic [16:0] u;
  logic [14:0] p;
  logic [1:0]  quad_d;
  logic [13:0] pp_d;
  logic        swap_d;
  logic [13:0] pp_q;
  logic [29:0] x_q;
  logic [30:0] x2_d;
  logic [1:0]  quad_q [NFL];
  logic        swap_q [NFL];

  // horner lines
  logic [29:0] xl_q  [NLN];
  logic [29:0] x2l_q [NLN];
  logic [30:0] a_s_d [NPH];
  logic [30:0] a_c_d [NPH];
  logic [30:0] a_s_q [NPH];
  logic [30:0] a_c_q [NPH];
  logic [59:0] pr_s_q [NPH];
  logic [59:0] pr_c_q [NPH];
  logic [30:0] ah_s_q [NPH];
  logic [30:0] ah_c_q [NPH];
  logic [30:0] t_s_q [NPH];
  logic [30:0] t_c_q [NPH];
  logic [30:0] s_raw_q;
  logic [30:0] rc_q;
  logic [30:0] c_oct;
  logic [30:0] sa;
  logic [30:0] ca;
  sincos_t     sc_d;
  sincos_t     sc_q;

  always_comb begin
    ang_ext = 18'(angle_i);
    ang_wrap = ang_ext[17] ? ang_ext + 18'sd92160 : ang_ext;
    u = ang_wrap[16:0];
    if (u >= 17'(3 * QUARTER_UNITS)) begin
      quad_d = 2'd3;
      p = 15'(u - 17'(3 * QUARTER_UNITS));
    end else if (u >= 17'(2 * QUARTER_UNITS)) begin
      quad_d = 2'd2;
      p = 15'(u - 17'(2 * QUARTER_UNITS));
    end else if (u >= 17'(QUARTER_UNITS)) begin
      quad_d = 2'd1;
      p = 15'(u - 17'(QUARTER_UNITS));
    end else begin
      quad_d = 2'd0;
      p = u[14:0];
    end
    if (p <= 15'(EIGHTH_UNITS)) begin
      pp_d = p[13:0];
      swap_d = 1'b0;
    end else begin
      pp_d = 14'(15'(QUARTER_UNITS) - p);
      swap_d = 1'b1;
    end
  end

  assign x2_d = mul_q30({1'b0, x_q}, {1'b0, x_q});

  always_comb begin
    a_s_d[0] = {1'b0, x2l_q[0]};
    a_c_d[0] = {1'b0, x2l_q[0]};
    for (int k = 1; k < NPH; k++) begin
      a_s_d[k] = mul_q30({1'b0, x2l_q[3*k]}, t_s_q[k-1]);
      a_c_d[k] = mul_q30({1'b0, x2l_q[3*k]}, t_c_q[k-1]);
    end
  end

  // octant swap, then quadrant rotation
  always_comb begin
    c_oct = Q30_ONE - (rc_q >> 1);
    sa = swap_q[NFL-1] ? c_oct : s_raw_q;
    ca = swap_q[NFL-1] ? s_raw_q : c_oct;
    case (quad_q[NFL-1])
      2'd0: begin
        sc_d.s = signed'({1'b0, sa});
        sc_d.c = signed'({1'b0, ca});
      end
      2'd1: begin
        sc_d.s = signed'({1'b0, ca});
        sc_d.c = -signed'({1'b0, sa});
      end
      2'd2: begin
        sc_d.s = -signed'({1'b0, sa});
        sc_d.c = -signed'({1'b0, ca});
      end
      default: begin
        sc_d.s = -signed'({1'b0, ca});
        sc_d.c = signed'({1'b0, sa});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q <= pp_d;
      quad_q[0] <= quad_d;
      swap_q[0] <= swap_d;
      for (int i = 1; i < NFL; i++) begin
        quad_q[i] <= quad_q[i-1];
        swap_q[i] <= swap_q[i-1];
      end
      x_q <= 30'((41'(pp_q) * 41'(RAD_PER_UNIT_Q40) + 41'd512) >> 10);
      xl_q[0] <= x_q;
      x2l_q[0] <= x2_d[29:0];
      for (int i = 1; i < NLN; i++) begin
        xl_q[i] <= xl_q[i-1];
        x2l_q[i] <= x2l_q[i-1];
      end
      for (int k = 0; k < NPH; k++) begin
        a_s_q[k] <= a_s_d[k];
        a_c_q[k] <= a_c_d[k];
        pr_s_q[k] <= 60'(a_s_q[k]) * 60'(SIN_RCP[k]);
        pr_c_q[k] <= 60'(a_c_q[k]) * 60'(COS_RCP[k]);
        ah_s_q[k] <= a_s_q[k];
        ah_c_q[k] <= a_c_q[k];
        t_s_q[k] <= Q30_ONE - 31'(div_fix(ah_s_q[k], pr_s_q[k], SIN_DIV[k]));
        t_c_q[k] <= Q30_ONE - 31'(div_fix(ah_c_q[k], pr_c_q[k], COS_DIV[k]));
      end
      s_raw_q <= mul_q30({1'b0, xl_q[NLN-1]}, t_s_q[NPH-1]);
      rc_q <= mul_q30({1'b0, x2l_q[NLN-1]}, t_c_q[NPH-1]);
      sc_q <= sc_d;
    end
  end

  assign sc_o = sc_q;

endmodule

// ===== hdl/euler_to_unit_quaternion.sv =====
// Euler XYZ angles to unit quaternion. Each input transfer carries three angles in
// 1/128 degree units (any 17-bit pattern, wrapping with the natural period); each
// output transfer carries the normalized quaternion w,x,y,z as signed fixed point
// with COMPONENT_WIDTH-2 fraction bits, saturated to +-1.0. A zero-length
// quaternion leaves as all zeros. The block is a single stall-as-one pipeline: one
// item per clock while the output is not held. Its depth is made up of the Horner
// sin/cos chain (17 stages), the product and square-sum stages (6), the square root
// (two root bits per stage, 16 stages), the load and output registers around the
// divider (2) and the divider that normalizes each component (two quotient bits per
// stage). When the output is held, the whole pipeline and s_axis_tready hold with
// it.
module euler_to_unit_quaternion #(
  parameter int COMPONENT_WIDTH = e2q_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // angle_x [16:0], angle_y [33:17], angle_z [50:34], zero pad above
  input  logic [e2q_pkg::IN_TDATA_W-1:0]              s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z from the low end, COMPONENT_WIDTH bits each
  output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]      m_axis_tdata
);
  import e2q_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int FB = CW - 2;
  localparam int OUT_W = ((4 * CW + 7) / 8) * 8;
  localparam int QW = FB + 1;
  localparam int DW = 33 + FB;
  localparam int NDVS = (QW + 1) / 2;
  localparam int NSL = SQ_STAGES + 3;
  localparam int LAT = LAT_SC + 8 + SQ_STAGES + NDVS;
  localparam logic [QW-1:0] LIM_Q = QW'(64'd1 << FB);

  // pipeline advance: everything moves unless a finished result is held
  logic adv;
  logic [LAT-1:0] vld_q;

  sincos_t sc_x;
  sincos_t sc_y;
  sincos_t sc_z;

  // euler product
  logic signed [31:0] cpcy_q, spsy_q, crsp_q, srcp_q, crcp_q, srsp_q;
  logic signed [31:0] cr_q, sr_q, cy_q, sy_q;
  logic signed [31:0] prd_q [8];
  logic signed [32:0] qv_q [4];

  // squared length
  logic [31:0] mag_d [4];
  logic [63:0] sq_q [4];
  logic [63:0] s01_q, s23_q;
  logic [31:0] ml_q [NSL][4];
  logic        sgl_q [NSL][4];

  // square root
  logic [63:0] sqv_d [SQ_STAGES+1];
  logic [63:0] sqr_d [SQ_STAGES+1];
  logic [63:0] sqv_q [SQ_STAGES+1];
  logic [63:0] sqr_q [SQ_STAGES+1];
  logic [31:0] n_w;

  // normalizing division
  logic [DW-1:0] rem_d [NDVS+1][4];
  logic [QW-1:0] quo_d [NDVS+1][4];
  logic [DW-1:0] rem_q [NDVS+1][4];
  logic [QW-1:0] quo_q [NDVS+1][4];
  logic          sat_d [4];
  logic          sat_q [NDVS+1][4];
  logic          sgn_q [NDVS+1][4];
  logic [31:0]   nd_q [NDVS+1];
  logic [CW-1:0] od_d [4];
  logic [CW-1:0] od_q [4];

  assign adv = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // half-angle sin/cos for roll, pitch and yaw
  e2q_sincos u_sc_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(s_axis_tdata[ANGLE_W-1:0]),
    .sc_o   (sc_x)
  );

  e2q_sincos u_sc_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(s_axis_tdata[2*ANGLE_W-1:ANGLE_W]),
    .sc_o   (sc_y)
  );

  e2q_sincos u_sc_z (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(s_axis_tdata[3*ANGLE_W-1:2*ANGLE_W]),
    .sc_o   (sc_z)
  );

  // component magnitudes for the squared length
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag_d[l] = qv_q[l][32] ? 32'(-qv_q[l]) : qv_q[l][31:0];
    end
  end

  // restoring square root, two root bits per stage
  always_comb begin : sqrt_next
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    sqv_d[0] = s01_q + s23_q;
    sqr_d[0] = '0;
    for (int k = 1; k <= SQ_STAGES; k++) begin
      v = sqv_q[k-1];
      r = sqr_q[k-1];
      for (int j = 0; j < 2; j++) begin
        b = 64'(1) << (62 - 2 * (2 * (k - 1) + j));
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      sqv_d[k] = v;
      sqr_d[k] = r;
    end
  end

  assign n_w = sqr_q[SQ_STAGES][31:0];

  // rounded quotient |q| * 2^FB / n, two quotient bits per stage
  always_comb begin : div_next
    logic [DW-1:0] rem;
    logic [DW-1:0] nsh;
    logic [QW-1:0] quo;
    int            b;
    for (int l = 0; l < 4; l++) begin
      rem_d[0][l] = (DW'(ml_q[NSL-1][l]) << FB) + DW'(n_w >> 1);
      quo_d[0][l] = '0;
      // quotient would reach twice full scale: saturate without dividing
      sat_d[l] = {1'b0, ml_q[NSL-1][l]} >= {n_w, 1'b0};
    end
    for (int k = 1; k <= NDVS; k++) begin
      for (int l = 0; l < 4; l++) begin
        rem = rem_q[k-1][l];
        quo = quo_q[k-1][l];
        for (int j = 0; j < 2; j++) begin
          b = FB - 2 * (k - 1) - j;
          if (b >= 0) begin
            nsh = DW'(nd_q[k-1]) << b;
            if (rem >= nsh) begin
              rem = rem - nsh;
              quo = {quo[QW-2:0], 1'b1};
            end else begin
              quo = {quo[QW-2:0], 1'b0};
            end
          end
        end
        rem_d[k][l] = rem;
        quo_d[k][l] = quo;
      end
    end
  end

  // saturate, restore sign; zero length gives zeros
  always_comb begin : out_next
    logic [QW-1:0] qm;
    for (int l = 0; l < 4; l++) begin
      qm = (sat_q[NDVS][l] || (quo_q[NDVS][l] > LIM_Q)) ? LIM_Q : quo_q[NDVS][l];
      if (nd_q[NDVS] == '0) begin
        od_d[l] = '0;
      end else if (sgn_q[NDVS][l]) begin
        od_d[l] = CW'(0) - CW'(qm);
      end else begin
        od_d[l] = CW'(qm);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // pairwise half-angle products
      cpcy_q <= mul_s30(sc_y.c, sc_z.c);
      spsy_q <= mul_s30(sc_y.s, sc_z.s);
      crsp_q <= mul_s30(sc_x.c, sc_y.s);
      srcp_q <= mul_s30(sc_x.s, sc_y.c);
      crcp_q <= mul_s30(sc_x.c, sc_y.c);
      srsp_q <= mul_s30(sc_x.s, sc_y.s);
      cr_q <= sc_x.c;
      sr_q <= sc_x.s;
      cy_q <= sc_z.c;
      sy_q <= sc_z.s;
      // third factor of each term
      prd_q[0] <= mul_s30(cr_q, cpcy_q);
      prd_q[1] <= mul_s30(sr_q, spsy_q);
      prd_q[2] <= mul_s30(sr_q, cpcy_q);
      prd_q[3] <= mul_s30(cr_q, spsy_q);
      prd_q[4] <= mul_s30(crsp_q, cy_q);
      prd_q[5] <= mul_s30(srcp_q, sy_q);
      prd_q[6] <= mul_s30(crcp_q, sy_q);
      prd_q[7] <= mul_s30(srsp_q, cy_q);
      // w, x, y, z in q30
      qv_q[0] <= 33'(prd_q[0]) + 33'(prd_q[1]);
      qv_q[1] <= 33'(prd_q[2]) - 33'(prd_q[3]);
      qv_q[2] <= 33'(prd_q[4]) + 33'(prd_q[5]);
      qv_q[3] <= 33'(prd_q[6]) - 33'(prd_q[7]);
      for (int l = 0; l < 4; l++) begin
        sq_q[l] <= 64'(mag_d[l]) * 64'(mag_d[l]);
        ml_q[0][l] <= mag_d[l];
        sgl_q[0][l] <= qv_q[l][32];
        for (int i = 1; i < NSL; i++) begin
          ml_q[i][l] <= ml_q[i-1][l];
          sgl_q[i][l] <= sgl_q[i-1][l];
        end
      end
      s01_q <= sq_q[0] + sq_q[1];
      s23_q <= sq_q[2] + sq_q[3];
      for (int k = 0; k <= SQ_STAGES; k++) begin
        sqv_q[k] <= sqv_d[k];
        sqr_q[k] <= sqr_d[k];
      end
      nd_q[0] <= n_w;
      for (int l = 0; l < 4; l++) begin
        sat_q[0][l] <= sat_d[l];
        sgn_q[0][l] <= sgl_q[NSL-1][l];
      end
      for (int k = 0; k <= NDVS; k++) begin
        for (int l = 0; l < 4; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          quo_q[k][l] <= quo_d[k][l];
        end
      end
      for (int k = 1; k <= NDVS; k++) begin
        nd_q[k] <= nd_q[k-1];
        for (int l = 0; l < 4; l++) begin
          sat_q[k][l] <= sat_q[k-1][l];
          sgn_q[k][l] <= sgn_q[k-1][l];
        end
      end
      for (int l = 0; l < 4; l++) begin
        od_q[l] <= od_d[l];
      end
    end
  end

  assign m_axis_tdata = OUT_W'({od_q[3], od_q[2], od_q[1], od_q[0]});

endmodule

// ===== hdl/e2q_checker.sv =====
`include "assert_macros.svh"

module e2q_checker #(
  parameter int COMPONENT_WIDTH = e2q_pkg::COMPONENT_WIDTH_DEF
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   s_axis_tvalid,
  input logic                                   s_axis_tready,
  input logic [e2q_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  import e2q_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam logic signed [CW-1:0] POS_LIM = CW'(64'd1 << (CW - 2));
  localparam logic signed [CW-1:0] NEG_LIM = -POS_LIM;

  logic lanes_ok;

  // every component stays within plus or minus one
  always_comb begin : lane_check
    logic signed [CW-1:0] comp;
    lanes_ok = 1'b1;
    for (int l = 0; l < 4; l++) begin
      comp = signed'(m_axis_tdata[l*CW +: CW]);
      if (comp > POS_LIM || comp < NEG_LIM) begin
        lanes_ok = 1'b0;
      end
    end
  end

  `E2Q_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while held")
  `E2Q_ASSERT(a_ready_when_free, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "input refused with output empty")
  `E2Q_ASSERT_NEVER(a_stall_blocks_in, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready && s_axis_tready, "input taken while result held")
  `E2Q_ASSERT(a_unit_range, clk_i, rst_ni, m_axis_tvalid |-> lanes_ok, "component beyond unit range")

endmodule

bind euler_to_unit_quaternion e2q_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_e2q_checker (.*);

// ===== dv/euler_to_unit_quaternion_test.sv =====
`timescale 1ns / 1ps

module euler_to_unit_quaternion_test;
  import e2q_pkg::*;

  localparam int CW = 16;
  localparam int FB = CW - 2;
  localparam int OUT_W = ((4 * CW + 7) / 8) * 8;
  localparam int N_RANDOM = 1150;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [ANGLE_W-1:0] ax;
    logic [ANGLE_W-1:0] ay;
    logic [ANGLE_W-1:0] az;
  } angles_t;

  typedef struct {
    logic [CW-1:0] w;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } quat_t;

  typedef struct {
    angles_t a;
    bit      typed;
    quat_t   q;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  quat_t quat_expected[$];
  int    n_errors = 0;
  bit    stim_done = 1'b0;

  always #2 clk_i = ~clk_i;

  euler_to_unit_quaternion #(.COMPONENT_WIDTH(CW)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // unsigned q30 product, round half up
  function automatic longint unsigned umul30(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // signed q30 product, round half away from zero
  function automatic longint smul30(longint a, longint b);
    longint unsigned r;
    r = umul30((a < 0) ? -a : a, (b < 0) ? -b : b);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // taylor sin/cos of a folded half angle in [0, 45] degrees
  task automatic octant_sincos(input longint unsigned p, output longint unsigned s,
                               output longint unsigned c);
    longint unsigned one, rad, rad2, t;
    one = 64'd1 << 30;
    rad = (p * 64'd74961321 + 64'd512) >> 10;
    rad2 = umul30(rad, rad);
    t = one - rad2 / 72;
    t = one - umul30(rad2, t) / 42;
    t = one - umul30(rad2, t) / 20;
    t = one - umul30(rad2, t) / 6;
    s = umul30(rad, t);
    t = one - rad2 / 90;
    t = one - umul30(rad2, t) / 56;
    t = one - umul30(rad2, t) / 30;
    t = one - umul30(rad2, t) / 12;
    c = one - umul30(rad2, t) / 2;
  endtask

  // half-angle sin/cos of one raw angle field, any bit pattern
  task automatic half_angle_sincos(input logic [ANGLE_W-1:0] raw, output longint s,
                                   output longint c);
    longint v, u, p;
    longint unsigned s0, c0;
    int quad;
    v = longint'($signed(raw));
    u = v % HALF_TURN_UNITS;
    if (u < 0) u += HALF_TURN_UNITS;
    quad = int'(u / QUARTER_UNITS);
    p = u % QUARTER_UNITS;
    if (p <= EIGHTH_UNITS) octant_sincos(p, s0, c0);
    else octant_sincos(QUARTER_UNITS - p, c0, s0);
    case (quad)
      0: begin s = s0; c = c0; end
      1: begin s = c0; c = -longint'(s0); end
      2: begin s = -longint'(s0); c = -longint'(c0); end
      default: begin s = -longint'(c0); c = s0; end
    endcase
  endtask

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] normalize_component(longint comp, longint unsigned len);
    longint unsigned mag, q;
    mag = (comp < 0) ? -comp : comp;
    q = ((mag << FB) + len / 2) / len;
    if (q > (64'd1 << FB)) q = 64'd1 << FB;
    return (comp < 0) ? CW'(-q) : CW'(q);
  endfunction

  task automatic euler_to_quat(input angles_t a, output quat_t r);
    longint sr, cr, sp, cp, sy, cy, cpcy, spsy;
    longint q[4];
    longint unsigned m, sum, len;
    half_angle_sincos(a.ax, sr, cr);
    half_angle_sincos(a.ay, sp, cp);
    half_angle_sincos(a.az, sy, cy);
    cpcy = smul30(cp, cy);
    spsy = smul30(sp, sy);
    q[0] = smul30(cr, cpcy) + smul30(sr, spsy);
    q[1] = smul30(sr, cpcy) - smul30(cr, spsy);
    q[2] = smul30(smul30(cr, sp), cy) + smul30(smul30(sr, cp), sy);
    q[3] = smul30(smul30(cr, cp), sy) - smul30(smul30(sr, sp), cy);
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      m = (q[i] < 0) ? -q[i] : q[i];
      sum += m * m;
    end
    if (sum == 0) begin
      r = '{default: '0};
    end else begin
      len = floor_sqrt(sum);
      r.w = normalize_component(q[0], len);
      r.x = normalize_component(q[1], len);
      r.y = normalize_component(q[2], len);
      r.z = normalize_component(q[3], len);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                 input logic [CW-1:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got), $signed(want),
             $realtime);
    n_errors++;
  endtask

  // drive one transfer after a random gap, expectation queued when it is accepted;
  // tvalid stays high into the next transfer when its gap is zero
  task automatic send_angles(input angles_t a, input bit typed, input quat_t q_typed);
    quat_t q;
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= IN_TDATA_W'({a.az, a.ay, a.ax});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) q = q_typed;
    else euler_to_quat(a, q);
    quat_expected.push_back(q);
    @(negedge clk_i);
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    case ($urandom_range(0, 5))
      0: return ANGLE_W'($urandom);                          // any pattern, wraps
      1: return ANGLE_W'($urandom_range(0, 64) * 1440);      // multiples of 11.25 deg
      2: return ANGLE_W'(($urandom_range(0, 1) ? 46080 : -46080)
                         + int'($urandom_range(0, 4)) - 2);
      default: return ANGLE_W'($urandom_range(0, 92160) - 46080);
    endcase
  endfunction

  // output side: random stalls, compare against oldest expectation
  initial begin
    quat_t got, want;
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.w = m_axis_tdata[0*CW +: CW];
      got.x = m_axis_tdata[1*CW +: CW];
      got.y = m_axis_tdata[2*CW +: CW];
      got.z = m_axis_tdata[3*CW +: CW];
      if (quat_expected.size() == 0) begin
        $display("unexpected output transfer at %0t", $realtime);
        n_errors++;
      end else begin
        want = quat_expected.pop_front();
        if (got.w !== want.w) report_mismatch("quat_w", got.w, want.w);
        if (got.x !== want.x) report_mismatch("quat_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("quat_y", got.y, want.y);
        if (got.z !== want.z) report_mismatch("quat_z", got.z, want.z);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    quat_t unused_q;
    angles_t a;
    unused_q = '{default: '0};
    // typed rows: identity, half turns about each axis, a full turn about x; rest predicted
    rows.push_back('{'{17'd0, 17'd0, 17'd0}, 1'b1, '{16'sd16384, 16'd0, 16'd0, 16'd0}});
    rows.push_back('{'{17'd23040, 17'd0, 17'd0}, 1'b1, '{16'd0, 16'sd16384, 16'd0, 16'd0}});
    rows.push_back('{'{17'd0, 17'd23040, 17'd0}, 1'b1, '{16'd0, 16'd0, 16'sd16384, 16'd0}});
    rows.push_back('{'{17'd0, 17'd0, 17'd23040}, 1'b1, '{16'd0, 16'd0, 16'd0, 16'sd16384}});
    rows.push_back('{'{17'd46080, 17'd0, 17'd0}, 1'b1, '{-16'sd16384, 16'd0, 16'd0, 16'd0}});
    rows.push_back('{'{-17'sd46080, -17'sd46080, -17'sd46080}, 1'b0, unused_q});
    rows.push_back('{'{17'd46080, 17'd46080, 17'd46080}, 1'b0, unused_q});
    rows.push_back('{'{17'h0FFFF, 17'h0FFFF, 17'h0FFFF}, 1'b0, unused_q});  // beyond 360
    rows.push_back('{'{17'h10000, 17'h10000, 17'h10000}, 1'b0, unused_q});
    rows.push_back('{'{17'h1FFFF, 17'h00001, 17'h1FFFF}, 1'b0, unused_q});
    rows.push_back('{'{17'd11520, 17'd11520, 17'd11520}, 1'b0, unused_q});  // octant fold edge
    rows.push_back('{'{17'd11521, 17'd11519, 17'd34560}, 1'b0, unused_q});
    rows.push_back('{'{17'd5760, 17'd17280, 17'd40320}, 1'b0, unused_q});
    rows.push_back('{'{17'd92160, 17'd0, 17'd0}, 1'b0, unused_q});
    rows.push_back('{'{17'd23040, 17'd23040, 17'd23040}, 1'b0, unused_q});
    rows.push_back('{'{17'h15555, 17'h0AAAA, 17'h1AAAA}, 1'b0, unused_q});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_angles(rows[i].a, rows[i].typed, rows[i].q);

    for (int i = 0; i < N_RANDOM; i++) begin
      // one hold-off: let the pipeline drain fully mid-run
      if (i == N_RANDOM / 2) begin
        s_axis_tvalid <= 1'b0;
        wait (quat_expected.size() == 0);
        @(negedge clk_i);
      end
      a.ax = random_angle();
      a.ay = random_angle();
      a.az = random_angle();
      send_angles(a, 1'b0, unused_q);
    end
    s_axis_tvalid <= 1'b0;

    wait (quat_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // watchdog: ~1200 items x (gap + stall + depth) stays far below this
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
